// ===== rtl/core/mre_pkg.sv =====
// Package for the R-format execute block: funct codes and the structs
// passed between the register file, the execute logic and the top level.
// No dependencies.
package mre_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned NumRegs = 32;

  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSub  = 6'h22;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnSlt  = 6'h2a;
  localparam logic [5:0] FnSltu = 6'h2b;

  localparam logic [XLEN-1:0] PcStep = 32'd4;

  // Register file write port.
  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] idx;
    logic [XLEN-1:0]     data;
  } wr_t;

  // Outcome of one executed instruction.
  typedef struct packed {
    logic                we;
    logic [RegAddrW-1:0] idx;
    logic [XLEN-1:0]     value;
    logic [XLEN-1:0]     npc;
    logic                unknown;
  } exec_res_t;

endpackage

// ===== rtl/core/mips_rtype_execute.sv =====
// Top level of the R-format execute block: operand stage, execute, result register.
// Depends on mre_pkg, mre_regfile and mre_alu.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, instruction_word_i | into block
//   out     | out_valid_o, out_ready_i, write_enable_o,  | out of block
//           | write_index_o, write_value_o, next_pc_o,   |
//           | unknown_funct_o                            |
//
// One instruction per cycle sustained while the output is not held; the register file is
// read as an instruction transfers in, and the instruction executes into the result
// register as it leaves the operand stage.
// The register file write and the pc update happen as an instruction moves into
// the result register; a same-cycle write is forwarded to the next operand read.
// Reset zeroes the pc and marks every register as reading zero, with no sweep.
// While the result register is held, the operand stage holds, and the input
// stalls once the operand stage is also occupied.
module mips_rtype_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [4:0]  write_index_o,
  output logic [31:0] write_value_o,
  output logic [31:0] next_pc_o,
  output logic        unknown_funct_o
);

  logic                      s1_valid_q, s1_valid_d;
  logic [31:0]               instr_q;
  logic                      out_valid_q, out_valid_d;
  mre_pkg::exec_res_t        res_q;
  mre_pkg::exec_res_t        exec_res;
  logic [mre_pkg::XLEN-1:0]  pc_q;
  logic [mre_pkg::XLEN-1:0]  rs_data, rt_data;
  logic                      in_xfer, advance;
  mre_pkg::wr_t              wr;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign wr.en   = advance && exec_res.we;
  assign wr.idx  = exec_res.idx;
  assign wr.data = exec_res.value;

  mre_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rs_i      (instruction_word_i[25:21]),
    .rt_i      (instruction_word_i[20:16]),
    .wr_i      (wr),
    .rs_data_o (rs_data),
    .rt_data_o (rt_data)
  );

  mre_alu u_alu (
    .funct_i (instr_q[5:0]),
    .shamt_i (instr_q[10:6]),
    .rd_i    (instr_q[15:11]),
    .a_i     (rs_data),
    .b_i     (rt_data),
    .pc_i    (pc_q),
    .res_o   (exec_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        pc_q <= exec_res.npc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      instr_q <= instruction_word_i;
    end
    if (advance) begin
      res_q <= exec_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = res_q.we;
  assign write_index_o   = res_q.idx;
  assign write_value_o   = res_q.value;
  assign next_pc_o       = res_q.npc;
  assign unknown_funct_o = res_q.unknown;

  a_pc_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (pc_q == res_q.npc))
    else $error("pc differs from the last reported next pc");

  a_no_write_on_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_res.unknown && s1_valid_q) |-> !exec_res.we)
    else $error("unknown funct would write a register");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

endmodule

// ===== rtl/core/mre_regfile.sv =====
// 32 x 32-bit register file with two registered read ports and one write port.
// Entries read as zero until written; a write in the same cycle is forwarded.
// Depends on mre_pkg.
module mre_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [mre_pkg::RegAddrW-1:0]   rs_i,
  input  logic [mre_pkg::RegAddrW-1:0]   rt_i,
  input  mre_pkg::wr_t                   wr_i,
  output logic [mre_pkg::XLEN-1:0]       rs_data_o,
  output logic [mre_pkg::XLEN-1:0]       rt_data_o
);

  logic [mre_pkg::XLEN-1:0]    mem_q [mre_pkg::NumRegs];
  logic [mre_pkg::NumRegs-1:0] valid_q, valid_d;
  logic [mre_pkg::XLEN-1:0]    mem_a_q, mem_b_q, fwd_data_q;
  logic                        vld_a_q, vld_b_q, fwd_a_q, fwd_b_q;

  always_comb begin
    valid_d = valid_q;
    if (wr_i.en) begin
      valid_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_a_q    <= mem_q[rs_i];
      mem_b_q    <= mem_q[rt_i];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        vld_a_q <= valid_q[rs_i];
        vld_b_q <= valid_q[rt_i];
        // The array still holds the old value at this edge, so a write to the
        // same register is taken from the write port instead.
        fwd_a_q <= wr_i.en && (wr_i.idx == rs_i);
        fwd_b_q <= wr_i.en && (wr_i.idx == rt_i);
      end
    end
  end

  assign rs_data_o = fwd_a_q ? fwd_data_q : (vld_a_q ? mem_a_q : '0);
  assign rt_data_o = fwd_b_q ? fwd_data_q : (vld_b_q ? mem_b_q : '0);

  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> (wr_i.idx != '0))
    else $error("register zero was written");

  a_zero_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0])
    else $error("register zero marked as written");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> valid_q[$past(wr_i.idx)])
    else $error("written register not marked valid");

  a_forward_rs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_i.en && (wr_i.idx == rs_i)) |=> (rs_data_o == $past(wr_i.data)))
    else $error("same-cycle write not forwarded to rs");

endmodule

// ===== rtl/core/mre_alu.sv =====
// Execute logic: decodes funct and computes the result, write enable and next pc.
// Purely combinational. Depends on mre_pkg.
module mre_alu (
  input  logic [5:0]                     funct_i,
  input  logic [4:0]                     shamt_i,
  input  logic [mre_pkg::RegAddrW-1:0]   rd_i,
  input  logic [mre_pkg::XLEN-1:0]       a_i,
  input  logic [mre_pkg::XLEN-1:0]       b_i,
  input  logic [mre_pkg::XLEN-1:0]       pc_i,
  output mre_pkg::exec_res_t             res_o
);

  logic [mre_pkg::XLEN-1:0] value;
  logic [mre_pkg::XLEN-1:0] npc;
  logic                     arith;
  logic                     unknown;

  always_comb begin
    value   = '0;
    npc     = pc_i + mre_pkg::PcStep;
    arith   = 1'b1;
    unknown = 1'b0;
    unique case (funct_i) inside
      mre_pkg::FnAdd, mre_pkg::FnAddu: value = a_i + b_i;
      mre_pkg::FnSub, mre_pkg::FnSubu: value = a_i - b_i;
      mre_pkg::FnAnd:  value = a_i & b_i;
      mre_pkg::FnSlt:  value = {31'd0, ($signed(a_i) < $signed(b_i))};
      mre_pkg::FnSltu: value = {31'd0, (a_i < b_i)};
      mre_pkg::FnSll:  value = b_i << shamt_i;
      mre_pkg::FnSrl:  value = b_i >> shamt_i;
      mre_pkg::FnJr: begin
        arith = 1'b0;
        npc   = a_i;
      end
      default: begin
        arith   = 1'b0;
        unknown = 1'b1;
      end
    endcase
  end

  assign res_o.we      = arith && (rd_i != '0);
  assign res_o.idx     = rd_i;
  assign res_o.value   = value;
  assign res_o.npc     = npc;
  assign res_o.unknown = unknown;

endmodule

// ===== dv/mips_rtype_execute_tb.sv =====
// Self-checking testbench for mips_rtype_execute: predicts each R-format result from
// its own register file and pc copy, and checks every output transfer in order.
// Depends on mre_pkg and the mips_rtype_execute RTL.
module mips_rtype_execute_tb;

  localparam int CLK_PERIOD = 20;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD_CYCLES = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] instruction_word_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_enable_o;
  logic [4:0]  write_index_o;
  logic [31:0] write_value_o;
  logic [31:0] next_pc_o;
  logic        unknown_funct_o;

  mips_rtype_execute u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .write_enable_o     (write_enable_o),
    .write_index_o      (write_index_o),
    .write_value_o      (write_value_o),
    .next_pc_o          (next_pc_o),
    .unknown_funct_o    (unknown_funct_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Architectural state as this testbench sees it.
  logic [mre_pkg::XLEN-1:0] gpr [mre_pkg::NumRegs];
  logic [mre_pkg::XLEN-1:0] pc_model;

  mre_pkg::exec_res_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count;
  int words_sent;
  int results_checked;
  int writes_seen;
  int jumps_seen;
  int unknowns_seen;

  // Executes one instruction word on the local state and returns its outcome.
  function automatic mre_pkg::exec_res_t execute_word(input logic [31:0] word);
    logic [5:0]               fn;
    logic [4:0]               sh;
    logic [4:0]               rd;
    logic [4:0]               rt;
    logic [4:0]               rs;
    logic [mre_pkg::XLEN-1:0] a;
    logic [mre_pkg::XLEN-1:0] b;
    logic                     arith;
    mre_pkg::exec_res_t       res;
    fn = word[5:0];
    sh = word[10:6];
    rd = word[15:11];
    rt = word[20:16];
    rs = word[25:21];
    a = gpr[rs];
    b = gpr[rt];
    arith = 1'b1;
    res.idx = rd;
    res.value = '0;
    res.npc = pc_model + mre_pkg::PcStep;
    res.unknown = 1'b0;
    case (fn)
      mre_pkg::FnAdd, mre_pkg::FnAddu: res.value = a + b;
      mre_pkg::FnSub, mre_pkg::FnSubu: res.value = a - b;
      mre_pkg::FnAnd:  res.value = a & b;
      mre_pkg::FnSlt:  res.value = {31'b0, $signed(a) < $signed(b)};
      mre_pkg::FnSltu: res.value = {31'b0, a < b};
      mre_pkg::FnSll:  res.value = b << sh;
      mre_pkg::FnSrl:  res.value = b >> sh;
      mre_pkg::FnJr: begin
        arith = 1'b0;
        res.npc = a;
      end
      default: begin
        arith = 1'b0;
        res.unknown = 1'b1;
      end
    endcase
    res.we = arith && (rd != '0);
    if (res.we) gpr[rd] = res.value;
    pc_model = res.npc;
    return res;
  endfunction

  function automatic logic [31:0] rtype_word(input logic [4:0] rs, input logic [4:0] rt,
                                             input logic [4:0] rd, input logic [4:0] sh,
                                             input logic [5:0] fn);
    return {6'b0, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [5:0] supported_funct(input int sel);
    case (sel)
      0:       return mre_pkg::FnSll;
      1:       return mre_pkg::FnSrl;
      2:       return mre_pkg::FnJr;
      3:       return mre_pkg::FnAdd;
      4:       return mre_pkg::FnAddu;
      5:       return mre_pkg::FnSub;
      6:       return mre_pkg::FnSubu;
      7:       return mre_pkg::FnAnd;
      8:       return mre_pkg::FnSlt;
      default: return mre_pkg::FnSltu;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(input logic [31:0] word);
    mre_pkg::exec_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    instruction_word_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = execute_word(word);
    pending_results = {pending_results, res};
    words_sent++;
    if (res.we) writes_seen++;
    if (res.unknown) unknowns_seen++;
    if (word[5:0] == mre_pkg::FnJr) jumps_seen++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Extremes of every field, each funct, destination zero, jr, unknown functs
  // and nonzero opcode bits.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(rtype_word(5'd31, 5'd31, 5'd31, 5'd0, mre_pkg::FnAdd));
    send_word(rtype_word(5'd0, 5'd31, 5'd1, 5'd31, mre_pkg::FnAddu));
    send_word(rtype_word(5'd31, 5'd0, 5'd0, 5'd0, mre_pkg::FnSub));
    send_word(rtype_word(5'd1, 5'd31, 5'd31, 5'd0, mre_pkg::FnSubu));
    send_word(rtype_word(5'd16, 5'd15, 5'd15, 5'd0, mre_pkg::FnAnd));
    send_word(rtype_word(5'd31, 5'd1, 5'd2, 5'd0, mre_pkg::FnSlt));
    send_word(rtype_word(5'd1, 5'd31, 5'd3, 5'd0, mre_pkg::FnSltu));
    send_word(rtype_word(5'd0, 5'd31, 5'd4, 5'd31, mre_pkg::FnSll));
    send_word(rtype_word(5'd0, 5'd31, 5'd5, 5'd31, mre_pkg::FnSrl));
    send_word(rtype_word(5'd0, 5'd5, 5'd6, 5'd0, mre_pkg::FnSrl));
    send_word(rtype_word(5'd31, 5'd0, 5'd7, 5'd0, mre_pkg::FnJr));
    send_word(rtype_word(5'd0, 5'd0, 5'd0, 5'd0, mre_pkg::FnJr));
    send_word(rtype_word(5'd3, 5'd4, 5'd9, 5'd0, 6'h01));
    send_word(rtype_word(5'd3, 5'd4, 5'd10, 5'd7, 6'h09));
    send_word(32'hFC00_0000 | rtype_word(5'd2, 5'd3, 5'd8, 5'd0, mre_pkg::FnAdd));
    send_word(rtype_word(5'd2, 5'd3, 5'd0, 5'd0, mre_pkg::FnAdd));
    send_word(rtype_word(5'd31, 5'd31, 5'd0, 5'd31, mre_pkg::FnSlt));
    send_word(rtype_word(5'd31, 5'd31, 5'd31, 5'd31, mre_pkg::FnSltu));
    wait_idle();
  endtask

  // Random words: mostly supported functs, some arbitrary funct fields.
  task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
    logic [31:0] word;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) begin
      word = $urandom();
      if ($urandom_range(99) < 85) word[5:0] = supported_funct($urandom_range(9));
      send_word(word);
    end
    wait_idle();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    logic [31:0] word;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_req++;
    @(negedge clk_i);
    repeat (40) begin
      word = $urandom();
      word[5:0] = supported_funct($urandom_range(9));
      send_word(word);
    end
    wait_idle();
  endtask

  // Receiver readiness, updated at each falling edge. A new hold request starts
  // a long stretch with ready low, counted down here.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each output transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    mre_pkg::exec_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_error("output transfer with no instruction outstanding");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (write_enable_o !== want.we)
          report_error($sformatf("write_enable got %b expected %b", write_enable_o, want.we));
        if (write_index_o !== want.idx)
          report_error($sformatf("write_index got %0d expected %0d", write_index_o, want.idx));
        if (write_value_o !== want.value)
          report_error($sformatf("write_value got %h expected %h", write_value_o, want.value));
        if (next_pc_o !== want.npc)
          report_error($sformatf("next_pc got %h expected %h", next_pc_o, want.npc));
        if (unknown_funct_o !== want.unknown)
          report_error($sformatf("unknown_funct got %b expected %b", unknown_funct_o,
                                 want.unknown));
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 200_000);
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("FAIL mips_rtype_execute");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    instruction_word_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count = 0;
    words_sent = 0;
    results_checked = 0;
    writes_seen = 0;
    jumps_seen = 0;
    unknowns_seen = 0;
    for (int i = 0; i < mre_pkg::NumRegs; i++) gpr[i] = '0;
    pc_model = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(450, 30, 70);
    test_random(450, 70, 30);
    test_random(450, 0, 0);
    test_backpressure();

    $display("Covered %0d instructions (%0d register writes, %0d jr, %0d unknown functs),",
             words_sent, writes_seen, jumps_seen, unknowns_seen);
    $display("%0d results checked under random idling on both sides and one long stall.",
             results_checked);
    if (fail_count == 0) begin
      $display("PASS mips_rtype_execute");
    end else begin
      $display("FAIL mips_rtype_execute");
    end
    $finish;
  end

endmodule

// ===== mips_rtype_execute.f =====
rtl/core/mre_pkg.sv
rtl/core/mre_regfile.sv
rtl/core/mre_alu.sv
rtl/core/mips_rtype_execute.sv
dv/mips_rtype_execute_tb.sv
